FILE: rtl/bitmap_frame_allocator_unit_macros.svh
// assertion helpers for the frame allocator
// each macro expects clk and rst_n in scope
`ifndef BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define BFA_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("frame allocator assertion failed");

// next-cycle implication
`define BFA_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("frame allocator assertion failed");

`endif

FILE: rtl/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

  // field widths
  localparam int OP_W       = 3;
  localparam int ST_W       = 3;
  localparam int ADDR_W     = 48;  // address bits in use, equal to the field width
  localparam int CFG_W      = 17;
  localparam int FADDR_W    = 28;
  localparam int CNT_OUT_W  = 17;
  localparam int IN_DATA_W  = 2 * ADDR_W;
  localparam int OUT_DATA_W = 48;

  // bitmap word geometry
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int CHG_W  = 6;
  localparam int MODE_W = 2;

  // parameter defaults
  localparam int MAX_FRAMES_DEF       = 65536;
  localparam int FRAME_BYTES_LOG2_DEF = 12;

  // operations
  localparam logic [OP_W-1:0] OP_INIT      = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC     = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd2;
  localparam logic [OP_W-1:0] OP_MARK_USED = 3'd3;
  localparam logic [OP_W-1:0] OP_MARK_FREE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE         = 3'd0;
  localparam logic [ST_W-1:0] ST_NO_FREE      = 3'd1;
  localparam logic [ST_W-1:0] ST_MISALIGNED   = 3'd2;
  localparam logic [ST_W-1:0] ST_FRAME_ZERO   = 3'd3;
  localparam logic [ST_W-1:0] ST_OUT_OF_RANGE = 3'd4;
  localparam logic [ST_W-1:0] ST_ALREADY_FREE = 3'd5;

  // word unit modes
  localparam logic [MODE_W-1:0] WU_SET   = 2'd0;
  localparam logic [MODE_W-1:0] WU_CLEAR = 2'd1;
  localparam logic [MODE_W-1:0] WU_COUNT = 2'd2;
  localparam logic [MODE_W-1:0] WU_ALLOC = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [BIT_W-1:0]  lo;
    logic [BIT_W-1:0]  hi;
  } wu_ctl_t;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [CHG_W-1:0]  chg;
    logic              found;
    logic [BIT_W-1:0]  idx;
  } wu_res_t;

endpackage

FILE: rtl/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/bfa_word_unit.sv
`timescale 1ns / 1ps

module bfa_word_unit (
  input  logic [bfa_pkg::WORD_W-1:0] data,
  input  bfa_pkg::wu_ctl_t           ctl,
  output bfa_pkg::wu_res_t           res
);

  import bfa_pkg::*;

  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_W - 1);

  logic [WORD_W-1:0] range_mask;
  logic [WORD_W-1:0] sel;
  logic [WORD_W-1:0] new_word;
  logic [BIT_W-1:0]  idx;
  logic              found;

  // bits lo..hi of the word
  assign range_mask = ({WORD_W{1'b1}} << ctl.lo) & ({WORD_W{1'b1}} >> (TOP_BIT - ctl.hi));

  // free bits for set, count and alloc; used bits for clear
  assign sel   = (ctl.mode == WU_CLEAR) ? (data & range_mask) : (~data & range_mask);
  assign found = |sel;

  // lowest selected bit
  always_comb begin
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (sel[i]) begin
        idx = BIT_W'(i);
      end
    end
  end

  always_comb begin
    unique case (ctl.mode)
      WU_SET:   new_word = data | range_mask;
      WU_CLEAR: new_word = data & ~range_mask;
      WU_ALLOC: new_word = found ? (data | (WORD_W'(1) << idx)) : data;
      WU_COUNT: new_word = data;
    endcase
  end

  always_comb begin
    res.word  = new_word;
    res.chg   = CHG_W'($countones(sel));
    res.found = found;
    res.idx   = idx;
  end

endmodule

FILE: rtl/bitmap_frame_allocator_unit.sv
`timescale 1ns / 1ps
// an accepted request passes dispatch, the range checks for free and mark ops, a load, a
// word scan (alloc stops at its hit) and done; unknown ops, allocs with no free frames,
// rejected frees and empty marks go to done early; init rewrites the whole bitmap, one word
// a cycle, then answers; one request at a time, the next taken once the result is registered
// and no recount is owed; reset (synchronous, active low) runs a fill pass over every bitmap
// word, no requests taken; a total_frames write triggers a recount before the next request

module bitmap_frame_allocator_unit #(
  parameter int MAX_FRAMES       = bfa_pkg::MAX_FRAMES_DEF,
  parameter int FRAME_BYTES_LOG2 = bfa_pkg::FRAME_BYTES_LOG2_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bfa_pkg::IN_DATA_W-1:0] in_tdata,   // addr [47:0], length [95:48]
  input  logic [bfa_pkg::OP_W-1:0]      in_tuser,   // op [2:0]
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bfa_pkg::OUT_DATA_W-1:0] out_tdata, // grant_addr [27:0], free_frames [44:28]
  output logic [bfa_pkg::ST_W-1:0]      out_tuser,  // status [2:0]
  // total_frames register
  input  logic                          cfg_we,
  input  logic [bfa_pkg::CFG_W-1:0]     cfg_wdata
);

  import bfa_pkg::*;

  `include "bitmap_frame_allocator_unit_macros.svh"

  // geometry derived from the frame limit
  localparam int NWORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
  localparam int WW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;   // word pointer
  localparam int FW     = WW + BIT_W;                          // frame index
  localparam int TW     = $clog2(MAX_FRAMES + 1);              // total and count
  localparam int L      = FRAME_BYTES_LOG2;

  // sequencer states
  localparam logic [2:0] S_FILL     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_DISPATCH = 3'd2;
  localparam logic [2:0] S_PREP_A   = 3'd3;
  localparam logic [2:0] S_PREP_B   = 3'd4;
  localparam logic [2:0] S_LOAD     = 3'd5;
  localparam logic [2:0] S_SCAN     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  // control state
  logic [2:0]         state_r, state_nxt;
  logic               pending_r, pending_nxt;    // recount owed after a register write
  logic               fill_rep_r, fill_rep_nxt;  // fill pass answers an init request
  logic [TW-1:0]      teff_r, teff_nxt;          // frame total clipped to the limit
  logic [TW-1:0]      count_r, count_nxt;        // free frames below the total
  logic [WW-1:0]      w_r, w_nxt;                // word pointer
  logic               out_tvalid_r, out_tvalid_nxt;

  // request and work registers
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0]  limit_r, limit_nxt;
  logic [ADDR_W-1:0]  diff_r, diff_nxt;
  logic [FW-1:0]      first_r, first_nxt;
  logic [FW-1:0]      last_r, last_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [FADDR_W-1:0] res_faddr_r, res_faddr_nxt;
  logic [ST_W-1:0]    res_status_r, res_status_nxt;

  // output register
  logic [FADDR_W-1:0]   out_faddr_r, out_faddr_nxt;
  logic [ST_W-1:0]      out_status_r, out_status_nxt;
  logic [CNT_OUT_W-1:0] out_free_r, out_free_nxt;

  // bitmap ram
  logic              ram_we;
  logic [WW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  // shared word unit
  wu_ctl_t wu_ctl;
  wu_res_t wu_res;

  logic [WW-1:0]     first_word;
  logic [WW-1:0]     last_word;
  logic [ADDR_W-1:0] teff_addr;
  logic [ADDR_W-1:0] end_m1;
  logic [FW-1:0]     alloc_frame;
  logic [ADDR_W-1:0] alloc_faddr;

  bfa_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfa_word_unit u_word_unit (
    .data (ram_rdata),
    .ctl  (wu_ctl),
    .res  (wu_res)
  );

  assign first_word = first_r[FW-1:BIT_W];
  assign last_word  = last_r[FW-1:BIT_W];
  assign teff_addr  = {{(ADDR_W - TW){1'b0}}, teff_r};

  // last byte of a marked range, saturating at the managed limit
  assign end_m1 = (len_r > diff_r) ? (limit_r - ADDR_W'(1)) : (addr_r + len_r - ADDR_W'(1));

  assign alloc_frame = {w_r, wu_res.idx};
  assign alloc_faddr = {{(ADDR_W - FW){1'b0}}, alloc_frame} << L;

  // edge bits of the range only on its first and last word
  always_comb begin
    wu_ctl.mode = mode_r;
    wu_ctl.lo   = (w_r == first_word) ? first_r[BIT_W-1:0] : '0;
    wu_ctl.hi   = (w_r == last_word) ? last_r[BIT_W-1:0] : {BIT_W{1'b1}};
  end

  always_comb begin
    state_nxt      = state_r;
    pending_nxt    = pending_r;
    fill_rep_nxt   = fill_rep_r;
    teff_nxt       = teff_r;
    count_nxt      = count_r;
    w_nxt          = w_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    len_nxt        = len_r;
    limit_nxt      = limit_r;
    diff_nxt       = diff_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    mode_nxt       = mode_r;
    res_faddr_nxt  = res_faddr_r;
    res_status_nxt = res_status_r;
    out_faddr_nxt  = out_faddr_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;

    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = wu_res.word;
    ram_raddr = w_r;

    unique case (state_r)
      // every word to all ones, one word a cycle
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = {WORD_W{1'b1}};
        if (w_r == WW'(NWORDS - 1)) begin
          count_nxt    = '0;
          fill_rep_nxt = 1'b0;
          state_nxt    = fill_rep_r ? S_DONE : S_IDLE;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (pending_r) begin
          // recount free bits below the new total
          pending_nxt = 1'b0;
          count_nxt   = '0;
          mode_nxt    = WU_COUNT;
          first_nxt   = '0;
          last_nxt    = FW'(teff_r - 1'b1);
          if (teff_r != '0) begin
            state_nxt = S_LOAD;
          end
        end else if (in_tvalid) begin
          op_nxt    = in_tuser;
          addr_nxt  = in_tdata[ADDR_W-1:0];
          len_nxt   = in_tdata[IN_DATA_W-1:ADDR_W];
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        res_faddr_nxt  = '0;
        res_status_nxt = ST_DONE;
        unique case (op_r) inside
          OP_INIT: begin
            w_nxt        = '0;
            fill_rep_nxt = 1'b1;
            state_nxt    = S_FILL;
          end
          OP_ALLOC: begin
            res_status_nxt = ST_NO_FREE;
            if (count_r == '0 || teff_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              mode_nxt  = WU_ALLOC;
              first_nxt = '0;
              last_nxt  = FW'(teff_r - 1'b1);
              state_nxt = S_LOAD;
            end
          end
          OP_FREE, OP_MARK_USED, OP_MARK_FREE: begin
            limit_nxt = teff_addr << L;
            state_nxt = S_PREP_A;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      // range and free checks against the byte limit
      S_PREP_A: begin
        diff_nxt = limit_r - addr_r;
        if (op_r == OP_FREE) begin
          if (teff_r == '0) begin
            res_status_nxt = ST_OUT_OF_RANGE;
            state_nxt      = S_DONE;
          end else if (addr_r[L-1:0] != '0) begin
            res_status_nxt = ST_MISALIGNED;
            state_nxt      = S_DONE;
          end else if (addr_r == '0) begin
            res_status_nxt = ST_FRAME_ZERO;
            state_nxt      = S_DONE;
          end else if (addr_r >= limit_r) begin
            // aligned address, so this is frame >= total
            res_status_nxt = ST_OUT_OF_RANGE;
            state_nxt      = S_DONE;
          end else begin
            mode_nxt  = WU_CLEAR;
            first_nxt = addr_r[L+FW-1:L];
            last_nxt  = addr_r[L+FW-1:L];
            state_nxt = S_LOAD;
          end
        end else if (len_r == '0 || teff_r == '0 || addr_r >= limit_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_PREP_B;
        end
      end

      S_PREP_B: begin
        mode_nxt  = (op_r == OP_MARK_USED) ? WU_SET : WU_CLEAR;
        first_nxt = addr_r[L+FW-1:L];
        last_nxt  = end_m1[L+FW-1:L];
        state_nxt = S_LOAD;
      end

      // first word read, data arrives in the scan cycle
      S_LOAD: begin
        ram_raddr = first_word;
        w_nxt     = first_word;
        state_nxt = S_SCAN;
      end

      // one word a cycle: write back word w while reading w + 1
      S_SCAN: begin
        ram_raddr = w_r + 1'b1;
        unique case (mode_r)
          WU_SET: begin
            ram_we    = 1'b1;
            count_nxt = count_r - TW'(wu_res.chg);
          end
          WU_CLEAR: begin
            ram_we    = 1'b1;
            count_nxt = count_r + TW'(wu_res.chg);
            if (op_r == OP_FREE && wu_res.chg == '0) begin
              res_status_nxt = ST_ALREADY_FREE;
            end
          end
          WU_COUNT: begin
            count_nxt = count_r + TW'(wu_res.chg);
          end
          WU_ALLOC: begin
            if (wu_res.found) begin
              ram_we         = 1'b1;
              count_nxt      = count_r - 1'b1;
              res_faddr_nxt  = alloc_faddr[FADDR_W-1:0];
              res_status_nxt = ST_DONE;
            end
          end
        endcase
        if (mode_r == WU_ALLOC && wu_res.found) begin
          state_nxt = S_DONE;
        end else if (w_r == last_word) begin
          state_nxt = (mode_r == WU_COUNT) ? S_IDLE : S_DONE;
        end else begin
          w_nxt = w_r + 1'b1;
        end
      end

      // hand the result to the output register once it is free
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_faddr_nxt  = res_faddr_r;
          out_status_nxt = res_status_r;
          out_free_nxt   = CNT_OUT_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end
    endcase

    // register write, clipped to the frame limit
    if (cfg_we) begin
      teff_nxt    = (32'(cfg_wdata) > 32'(MAX_FRAMES)) ? TW'(MAX_FRAMES) : TW'(cfg_wdata);
      pending_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_FILL;
      pending_r    <= 1'b0;
      fill_rep_r   <= 1'b0;
      teff_r       <= '0;
      count_r      <= '0;
      w_r          <= '0;
      mode_r       <= WU_COUNT;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pending_r    <= pending_nxt;
      fill_rep_r   <= fill_rep_nxt;
      teff_r       <= teff_nxt;
      count_r      <= count_nxt;
      w_r          <= w_nxt;
      mode_r       <= mode_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    len_r        <= len_nxt;
    limit_r      <= limit_nxt;
    diff_r       <= diff_nxt;
    first_r      <= first_nxt;
    last_r       <= last_nxt;
    res_faddr_r  <= res_faddr_nxt;
    res_status_r <= res_status_nxt;
    out_faddr_r  <= out_faddr_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
  end

  // requests only taken between ops with no recount owed
  assign in_tready  = (state_r == S_IDLE) && !pending_r;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_DATA_W - FADDR_W - CNT_OUT_W){1'b0}}, out_free_r, out_faddr_r};
  assign out_tuser  = out_status_r;

  // an accepted request always leaves idle
  `BFA_ASSERT_NXT(a_accept_busy, in_tvalid && in_tready, state_r != S_IDLE)
  // free count never exceeds the managed total once settled
  `BFA_ASSERT_IMP(a_count_bound, state_r == S_IDLE && !pending_r, count_r <= teff_r)
  // the bitmap is only written by the fill pass or the scan
  `BFA_ASSERT_IMP(a_write_phase, ram_we, state_r == S_FILL || state_r == S_SCAN)
  // the scan stays inside its word range
  `BFA_ASSERT_IMP(a_scan_bound, state_r == S_SCAN, w_r >= first_word && w_r <= last_word)
  // a finished op reaches the output when the register is free
  `BFA_ASSERT_NXT(a_done_out, state_r == S_DONE && !out_tvalid_r, out_tvalid_r)

endmodule
